/* hdl/elev_sup_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// elev_sup_pkg
// Types, codes and sizes shared by the elevator supervisor.
// ---------------------------------------------------------------------------
package elev_sup_pkg;

  localparam int QUEUE_DEPTH = 3;
  localparam int ID_W        = 11;
  localparam int FLOOR_W     = 2;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR1_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR2_ID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR3_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAR_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ID  = 3'd4;

  localparam logic [ID_W-1:0] RST_FLOOR1_ID = 11'd513;
  localparam logic [ID_W-1:0] RST_FLOOR2_ID = 11'd514;
  localparam logic [ID_W-1:0] RST_FLOOR3_ID = 11'd515;
  localparam logic [ID_W-1:0] RST_CAR_ID    = 11'd512;
  localparam logic [ID_W-1:0] RST_DRIVE_ID  = 11'd257;

  localparam logic [7:0] ACT_REQ_LO   = 8'd1;
  localparam logic [7:0] ACT_REQ_HI   = 8'd3;
  localparam logic [7:0] ACT_REQ2_LO  = 8'd4;
  localparam logic [7:0] ACT_REQ2_HI  = 8'd6;
  localparam logic [7:0] ACT_REQ2_OFS = 8'd3;
  localparam logic [7:0] ACT_OPEN     = 8'd7;
  localparam logic [7:0] ACT_CLOSE    = 8'd8;

  localparam logic [3:0] FRAME_LEN_ONE = 4'd1;
  localparam logic [7:0] MOVE_ENABLE   = 8'h04;
  localparam int         DOOR_BIT      = 2;

  localparam logic [FLOOR_W-1:0] FLOOR_NONE = 2'd0;
  localparam logic [FLOOR_W-1:0] FLOOR_ONE  = 2'd1;
  localparam logic [FLOOR_W-1:0] FLOOR_TWO  = 2'd2;
  localparam logic [FLOOR_W-1:0] FLOOR_THREE = 2'd3;

  typedef enum logic [1:0] {
    ST_WAITING     = 2'd0,
    ST_DOOR_CLOSED = 2'd1,
    ST_MOVING      = 2'd2,
    ST_DOOR_OPEN   = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic            frame_present;
    logic [ID_W-1:0] frame_ident;
    logic [3:0]      frame_length;
    logic [7:0]      frame_byte;
    logic [7:0]      client_action;
  } in_item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [7:0]         cmd_byte;
    logic [1:0]         fsm_state;
    logic [FLOOR_W-1:0] car_position;
    logic [FLOOR_W-1:0] target_floor;
    logic               door_is_closed;
    logic [1:0]         pending_count;
  } out_item_t;

  typedef struct packed {
    logic [QUEUE_DEPTH-1:0][FLOOR_W-1:0] ent;
    logic [CNT_W-1:0]                    cnt;
    logic                                door_shut;
  } queue_t;

endpackage

`default_nettype wire

/* hdl/elevator_supervisor_fsm.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// elevator_supervisor_fsm
// Supervisor pass for a three-floor car: frame decode, client action,
// request queue and four-state dispatch machine.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one supervisor pass per transfer (optional bus frame plus an
//           optional client action).
//   out_* : one result per pass: move command and the state after the pass.
//   cfg_* : node identifier writes, index 0..4; always ready. Write only
//           while no pass is in flight.
// Path: from input transfer to result valid through the input register,
//   then the pass logic into the result register.
// Throughput: one pass per cycle unless stalled; the pass state updates in
//   the cycle the item moves from the input register into the result register.
// Reset: queue empty, door closed, car and target at floor one, machine
//   waiting, identifiers at their default values, both registers empty.
// Stall: a result not taken holds in the result register; the input
//   register still takes one more item, then in_ready drops until out_ready.
// ---------------------------------------------------------------------------
module elevator_supervisor_fsm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire elev_sup_pkg::in_item_t            in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output elev_sup_pkg::out_item_t                out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [elev_sup_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [elev_sup_pkg::ID_W-1:0]      cfg_data
);
  import elev_sup_pkg::*;

  logic [ID_W-1:0] floor1_id_r, floor2_id_r, floor3_id_r, car_id_r, drive_id_r;

  in_item_t    in_q_r;
  logic        in_vld_r;
  out_item_t   out_r, out_nxt;
  logic        out_vld_r;
  logic        advance;

  ctrl_state_t        state_r, state_nxt;
  queue_t             queue_r, queue_nxt;
  logic [FLOOR_W-1:0] pos_r, pos_nxt;
  logic [FLOOR_W-1:0] tgt_r, tgt_nxt;

  function automatic queue_t push_floor(queue_t q, logic [FLOOR_W-1:0] tgt,
                                        logic [FLOOR_W-1:0] fl);
    queue_t r;
    logic   dup;
    r   = q;
    dup = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((CNT_W'(i) < q.cnt) && (q.ent[i] == fl)) begin
        dup = 1'b1;
      end
    end
    if ((fl != FLOOR_NONE) && (q.cnt < CNT_W'(QUEUE_DEPTH)) && !dup) begin
      if (tgt == fl) begin
        r.door_shut = 1'b0;
      end
      r.ent[q.cnt[QIDX_W-1:0]] = fl;
      r.cnt = q.cnt + 1'b1;
    end
    return r;
  endfunction

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor1_id_r <= RST_FLOOR1_ID;
      floor2_id_r <= RST_FLOOR2_ID;
      floor3_id_r <= RST_FLOOR3_ID;
      car_id_r    <= RST_CAR_ID;
      drive_id_r  <= RST_DRIVE_ID;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLOOR1_ID: floor1_id_r <= cfg_data;
        CFG_FLOOR2_ID: floor2_id_r <= cfg_data;
        CFG_FLOOR3_ID: floor3_id_r <= cfg_data;
        CFG_CAR_ID:    car_id_r    <= cfg_data;
        CFG_DRIVE_ID:  drive_id_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAITING;
      queue_r <= '{ent: '0, cnt: '0, door_shut: 1'b1};
      pos_r   <= FLOOR_ONE;
      tgt_r   <= FLOOR_ONE;
    end else if (advance) begin
      state_r <= state_nxt;
      queue_r <= queue_nxt;
      pos_r   <= pos_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  always_comb begin
    queue_t             q;
    logic [FLOOR_W-1:0] fl;
    logic [7:0]         act;
    logic [7:0]         act_adj;
    logic               dispatch;

    q         = queue_r;
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    state_nxt = state_r;
    act       = in_q_r.client_action;
    act_adj   = act - ACT_REQ2_OFS;
    dispatch  = 1'b0;
    fl        = FLOOR_NONE;

    if (in_q_r.frame_present && (in_q_r.frame_length == FRAME_LEN_ONE)) begin
      if (in_q_r.frame_ident == floor1_id_r) begin
        q = push_floor(q, tgt_r, FLOOR_ONE);
      end else if (in_q_r.frame_ident == floor2_id_r) begin
        q = push_floor(q, tgt_r, FLOOR_TWO);
      end else if (in_q_r.frame_ident == floor3_id_r) begin
        q = push_floor(q, tgt_r, FLOOR_THREE);
      end else if (in_q_r.frame_ident == car_id_r) begin
        q = push_floor(q, tgt_r, in_q_r.frame_byte[FLOOR_W-1:0]);
        q.door_shut = in_q_r.frame_byte[DOOR_BIT];
      end else if (in_q_r.frame_ident == drive_id_r) begin
        pos_nxt = in_q_r.frame_byte[FLOOR_W-1:0];
      end
    end

    if ((act >= ACT_REQ_LO) && (act <= ACT_REQ_HI)) begin
      q = push_floor(q, tgt_r, act[FLOOR_W-1:0]);
    end else if ((act >= ACT_REQ2_LO) && (act <= ACT_REQ2_HI)) begin
      q = push_floor(q, tgt_r, act_adj[FLOOR_W-1:0]);
    end else if (act == ACT_OPEN) begin
      if (q.door_shut && (pos_nxt != FLOOR_NONE)) begin
        q.door_shut = 1'b0;
      end
    end else if (act == ACT_CLOSE) begin
      q.door_shut = 1'b1;
    end

    case (state_r)
      ST_WAITING: begin
        if (q.cnt != '0) begin
          dispatch = 1'b1;
        end else if (!q.door_shut) begin
          state_nxt = ST_DOOR_OPEN;
        end
      end
      ST_DOOR_CLOSED: begin
        if (q.cnt != '0) begin
          dispatch = 1'b1;
        end else begin
          state_nxt = ST_WAITING;
        end
      end
      ST_MOVING: begin
        if ((pos_nxt != FLOOR_NONE) && (pos_nxt == tgt_r)) begin
          q.door_shut = 1'b0;
          state_nxt   = ST_DOOR_OPEN;
        end
      end
      ST_DOOR_OPEN: begin
        if (q.door_shut) begin
          state_nxt = ST_DOOR_CLOSED;
        end
      end
      default: begin
        state_nxt = ST_WAITING;
      end
    endcase

    if (dispatch) begin
      fl = q.ent[0];
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q.ent[i] = q.ent[i+1];
      end
      q.ent[QUEUE_DEPTH-1] = FLOOR_NONE;
      q.cnt     = q.cnt - 1'b1;
      tgt_nxt   = fl;
      pos_nxt   = FLOOR_NONE;
      state_nxt = ST_MOVING;
    end

    queue_nxt              = q;
    out_nxt.cmd_valid      = dispatch;
    out_nxt.cmd_byte       = dispatch ? (MOVE_ENABLE | {6'd0, fl}) : 8'd0;
    out_nxt.fsm_state      = state_nxt;
    out_nxt.car_position   = pos_nxt;
    out_nxt.target_floor   = tgt_nxt;
    out_nxt.door_is_closed = q.door_shut;
    out_nxt.pending_count  = 2'(q.cnt);
  end

`ifndef SYNTHESIS
  a_cmd_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmd_valid |->
      (out_data.fsm_state == ST_MOVING) && (out_data.car_position == FLOOR_NONE))
    else $error("move command without moving state");

  a_cmd_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmd_valid |->
      (out_data.cmd_byte[1:0] == out_data.target_floor) &&
      (out_data.target_floor != FLOOR_NONE))
    else $error("move command floor mismatch");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_r.cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("request queue overflow");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_ready |-> !in_ready)
    else $error("input taken while both registers full");
`endif

endmodule

`default_nettype wire
